// ----- rtl/ittf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ittf_pkg;

  localparam logic [6:0] CH_ZERO    = 7'h30;
  localparam logic [6:0] CH_MINUS   = 7'h2D;
  localparam logic [6:0] CH_SPACE   = 7'h20;
  localparam logic [6:0] CH_LOWER_A = 7'h61;
  localparam logic [6:0] CH_UPPER_A = 7'h41;

  localparam int unsigned NUM_NIBBLES = 10;
  localparam int unsigned DIGIT_W     = 4 * NUM_NIBBLES;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned CONV_STEPS  = VALUE_W;
  localparam int unsigned STEP_W      = $clog2(CONV_STEPS);
  localparam int unsigned POS_W       = 7;
  localparam int unsigned DEC_RADIX   = 10;

  typedef struct packed {
    logic load;
    logic shift;
    logic measure;
    logic emit;
  } ittf_cmd_t;

  typedef struct packed {
    logic hex;
    logic last;
    logic slot_free;
  } ittf_sts_t;

endpackage

`default_nettype wire

// ----- rtl/ittf_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ittf_ctrl
  import ittf_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      s_tvalid_i,
  output logic           s_tready_o,
  input  wire ittf_sts_t sts_i,
  output ittf_cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_MEASURE,
    ST_EMIT
  } state_e;

  state_e              state_q;
  logic [STEP_W-1:0]   step_q;

  assign s_tready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o.load    = (state_q == ST_IDLE) && s_tvalid_i;
    cmd_o.shift   = (state_q == ST_CONVERT) && !sts_i.hex;
    cmd_o.measure = (state_q == ST_MEASURE);
    cmd_o.emit    = (state_q == ST_EMIT) && sts_i.slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          step_q <= '0;
          if (s_tvalid_i) begin
            state_q <= ST_CONVERT;
          end
        end
        ST_CONVERT: begin
          step_q <= step_q + 1'b1;
          if (sts_i.hex || step_q == STEP_W'(CONV_STEPS - 1)) begin
            state_q <= ST_MEASURE;
          end
        end
        ST_MEASURE: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (sts_i.slot_free && sts_i.last) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> (state_q == ST_CONVERT))
    else $error("Accepted request did not start conversion.");

  a_convert_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONVERT && step_q == STEP_W'(CONV_STEPS - 1)) |=> (state_q == ST_MEASURE))
    else $error("Conversion overran its step count.");

  a_last_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && sts_i.last) |=> s_tready_o)
    else $error("Controller did not return to idle after the last character.");

endmodule

`default_nettype wire

// ----- rtl/ittf_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ittf_dpath
  import ittf_pkg::*;
#(
  parameter int unsigned MAX_FIELD = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ittf_cmd_t          cmd_i,
  output ittf_sts_t               sts_o,
  input  wire logic [VALUE_W-1:0] value_i,
  input  wire logic               hex_base_i,
  input  wire logic               signed_mode_i,
  input  wire logic               upper_case_i,
  input  wire logic [5:0]         field_width_i,
  input  wire logic [1:0]         pad_mode_i,
  input  wire logic [5:0]         min_digits_i,
  input  wire logic               m_tready_i,
  output logic                    m_tvalid_o,
  output logic [6:0]              m_char_o,
  output logic                    m_last_o
);

  localparam logic [5:0] MaxField = 6'(MAX_FIELD);

  logic               hex_q, neg_q, upper_q, left_q, zfill_q;
  logic [5:0]         width_q, mind_q;
  logic [DIGIT_W-1:0] dig_q;
  logic [VALUE_W-1:0] bin_q;
  logic [POS_W-1:0]   pre_q, ds_q, de_q, last_q, pos_q;
  logic               out_valid_q, out_last_q;
  logic [6:0]         out_char_q;

  logic               neg_d;
  logic [VALUE_W-1:0] mag_d;
  logic [DIGIT_W-1:0] adj;
  logic [3:0]         nd_c;
  logic [POS_W-1:0]   nd7, lz_c, body_c, width7, fill_c, pre_c, zf_c, ds_c, de_c, last_c;
  logic [POS_W-1:0]   didx;
  logic [3:0]         dsel;
  logic [6:0]         dchar, fch, char_c;
  logic               slot_free;

  always_comb begin
    neg_d = !hex_base_i && signed_mode_i && value_i[VALUE_W-1];
    mag_d = neg_d ? (~value_i + 1'b1) : value_i;
  end

  always_comb begin
    for (int i = 0; i < NUM_NIBBLES; i++) begin
      adj[4*i +: 4] = (dig_q[4*i +: 4] >= 4'd5) ? (dig_q[4*i +: 4] + 4'd3) : dig_q[4*i +: 4];
    end
  end

  always_comb begin
    nd_c = 4'd1;
    for (int i = 1; i < NUM_NIBBLES; i++) begin
      if (dig_q[4*i +: 4] != 4'd0) begin
        nd_c = 4'(i + 1);
      end
    end
    nd7    = {3'b000, nd_c};
    lz_c   = ({1'b0, mind_q} > nd7) ? ({1'b0, mind_q} - nd7) : '0;
    body_c = {6'b0, neg_q} + lz_c + nd7;
    width7 = {1'b0, width_q};
    fill_c = (width7 > body_c) ? (width7 - body_c) : '0;
    pre_c  = (!left_q && !zfill_q) ? fill_c : '0;
    zf_c   = (!left_q && zfill_q) ? fill_c : '0;
    ds_c   = pre_c + {6'b0, neg_q} + lz_c + zf_c;
    de_c   = ds_c + nd7;
    last_c = de_c - 7'd1 + (left_q ? fill_c : '0);
  end

  always_comb begin
    didx = de_q - 7'd1 - pos_q;
    dsel = '0;
    for (int i = 0; i < NUM_NIBBLES; i++) begin
      if (didx[3:0] == 4'(i)) begin
        dsel = dig_q[4*i +: 4];
      end
    end
    dchar = (dsel < 4'(DEC_RADIX)) ? (CH_ZERO + {3'b000, dsel})
          : ((upper_q ? CH_UPPER_A : CH_LOWER_A) + {3'b000, dsel} - 7'(DEC_RADIX));
    fch   = zfill_q ? CH_ZERO : CH_SPACE;
    priority if (pos_q < pre_q) begin
      char_c = CH_SPACE;
    end else if (neg_q && pos_q == pre_q) begin
      char_c = CH_MINUS;
    end else if (pos_q < ds_q) begin
      char_c = CH_ZERO;
    end else if (pos_q < de_q) begin
      char_c = dchar;
    end else begin
      char_c = fch;
    end
  end

  assign slot_free = !out_valid_q || m_tready_i;

  always_comb begin
    sts_o.hex       = hex_q;
    sts_o.last      = (pos_q == last_q);
    sts_o.slot_free = slot_free;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hex_q   <= hex_base_i;
      neg_q   <= neg_d;
      upper_q <= upper_case_i;
      left_q  <= pad_mode_i[0];
      zfill_q <= pad_mode_i[1];
      width_q <= (field_width_i > MaxField) ? MaxField : field_width_i;
      mind_q  <= (min_digits_i > MaxField) ? MaxField : min_digits_i;
      dig_q   <= hex_base_i ? {{(DIGIT_W - VALUE_W){1'b0}}, mag_d} : '0;
      bin_q   <= mag_d;
    end else if (cmd_i.shift) begin
      {dig_q, bin_q} <= {adj[DIGIT_W-2:0], bin_q, 1'b0};
    end
    if (cmd_i.measure) begin
      pre_q  <= pre_c;
      ds_q   <= ds_c;
      de_q   <= de_c;
      last_q <= last_c;
      pos_q  <= '0;
    end else if (cmd_i.emit) begin
      pos_q  <= pos_q + 1'b1;
    end
    if (cmd_i.emit) begin
      out_char_q <= char_c;
      out_last_q <= (pos_q == last_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_char_o   = out_char_q;
  assign m_last_o   = out_last_q;

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> slot_free)
    else $error("Character emitted into an occupied output register.");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && pos_q >= ds_q && pos_q < de_q) |-> (didx < 7'(NUM_NIBBLES)))
    else $error("Digit index outside the digit register.");

  a_hex_top_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.measure && hex_q) |-> (dig_q[DIGIT_W-1:VALUE_W] == '0))
    else $error("Hex digits spilled above eight nibbles.");

  a_measure_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.measure |=> (pos_q == '0 && last_q >= de_q - 7'd1))
    else $error("Emission position not rewound after measurement.");

endmodule

`default_nettype wire

// ----- rtl/integer_to_text_formatter_top.sv -----
// Integer-to-text formatter.
// A request on the slave stream carries a 32-bit value and its format; the
// block answers with the ASCII text of the number on the master stream, one
// character per transfer, with tlast on the final character.
// After a request is taken, a decimal value goes through a binary to BCD
// shift-and-adjust loop; a hex value skips the shifting. A measure step then
// works out digit count, sign, leading zeros and fill, and the characters
// follow at one per cycle while the receiver takes them. A request gives at
// most MAX_FIELD + 1 characters, so 33 by default.
// A new request is taken as soon as the last character sits in the output
// register, even if the receiver has not yet taken it.
// When the receiver stalls, the output register holds its character and the
// block waits; nothing is lost. Reset clears the controller and the output
// valid, leaving the block idle and ready.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_text_formatter_top
  import ittf_pkg::*;
#(
  parameter int unsigned MAX_FIELD = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // value[31:0], upper_case[32], field_width[38:33], pad_mode[40:39],
  // min_digits[46:41], zero[47].
  input  wire logic [47:0] s_axis_tdata_i,
  // hex_base[0], signed_mode[1].
  input  wire logic [1:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // character[6:0], zero[7].
  output logic [7:0]       m_axis_tdata_o,
  output logic             m_axis_tlast_o
);

  ittf_cmd_t  cmd;
  ittf_sts_t  sts;
  logic [6:0] char_w;

  ittf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ittf_dpath #(
    .MAX_FIELD (MAX_FIELD)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .value_i       (s_axis_tdata_i[31:0]),
    .hex_base_i    (s_axis_tuser_i[0]),
    .signed_mode_i (s_axis_tuser_i[1]),
    .upper_case_i  (s_axis_tdata_i[32]),
    .field_width_i (s_axis_tdata_i[38:33]),
    .pad_mode_i    (s_axis_tdata_i[40:39]),
    .min_digits_i  (s_axis_tdata_i[46:41]),
    .m_tready_i    (m_axis_tready_i),
    .m_tvalid_o    (m_axis_tvalid_o),
    .m_char_o      (char_w),
    .m_last_o      (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {1'b0, char_w};

endmodule

`default_nettype wire
